// ===== design/diagonal_slot_coeff_mapper_macros.svh =====
// Assertion helpers shared by the mapper modules.
`ifndef DIAGONAL_SLOT_COEFF_MAPPER_MACROS_SVH
`define DIAGONAL_SLOT_COEFF_MAPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("diagonal slot mapper check failed");

// Next-cycle implication, disabled during reset.
`define DSCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("diagonal slot mapper check failed");

`endif

// ===== design/dscm_pkg.sv =====
package dscm_pkg;

    localparam int CoeffW     = 5;
    localparam int BlockW     = 12;
    localparam int CtW        = 12;
    localparam int SlotW      = 15;
    localparam int ColOutW    = 16;
    localparam int RowsW      = 13;
    localparam int ColsW      = 16;
    localparam int HeadWidthW = 13;
    localparam int HeadsW     = 9;
    localparam int LogW       = 4;
    localparam int PackedW    = 20;
    localparam int ProdW      = HeadsW + HeadWidthW;
    localparam int ApbDataW   = 32;
    localparam int ApbAddrW   = 5;

    localparam logic [PackedW-1:0] PackedMax = '1;

    typedef enum logic [2:0] {
        REG_ROWS_USED         = 3'd0,
        REG_COLS_TOTAL        = 3'd1,
        REG_HEAD_WIDTH_USED   = 3'd2,
        REG_HEADS_USED        = 3'd3,
        REG_LOG2_BLOCK_WIDTH  = 3'd4,
        REG_LOG2_HEADS        = 3'd5,
        REG_LOG2_ROWS         = 3'd6,
        REG_LOG2_DIAGS_PER_CT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [RowsW-1:0]      rows_used;
        logic [ColsW-1:0]      cols_total;
        logic [HeadWidthW-1:0] head_width_used;
        logic [HeadsW-1:0]     heads_used;
        logic [LogW-1:0]       log2_block_width;
        logic [LogW-1:0]       log2_heads;
        logic [LogW-1:0]       log2_rows;
        logic [LogW-1:0]       log2_diags_per_ct;
        logic [PackedW-1:0]    packed_width;
    } t_cfg;

endpackage

// ===== design/dscm_regs.sv =====
module dscm_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dscm_pkg::ApbAddrW-1:0]       paddr,
    input  logic [dscm_pkg::ApbDataW-1:0]       pwdata,
    output logic [dscm_pkg::ApbDataW-1:0]       prdata,
    output logic                                pready,
    output dscm_pkg::t_cfg                      o_cfg
);
    import dscm_pkg::*;

    `include "diagonal_slot_coeff_mapper_macros.svh"

    t_cfg                r_cfg;
    logic                r_pw_load;
    logic [PackedW-1:0]  r_packed_width;
    logic [PackedW-1:0]  n_packed_width;
    logic [ProdW-1:0]    pw_prod;
    logic                cfg_wr;
    t_reg_idx            wr_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_idx = t_reg_idx'(paddr[ApbAddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_used         <= RowsW'(1);
            r_cfg.cols_total        <= ColsW'(1);
            r_cfg.head_width_used   <= HeadWidthW'(1);
            r_cfg.heads_used        <= HeadsW'(1);
            r_cfg.log2_block_width  <= '0;
            r_cfg.log2_heads        <= '0;
            r_cfg.log2_rows         <= '0;
            r_cfg.log2_diags_per_ct <= '0;
            r_cfg.packed_width      <= '0;
        end else if (cfg_wr) begin
            case (wr_idx)
                REG_ROWS_USED:         r_cfg.rows_used         <= pwdata[RowsW-1:0];
                REG_COLS_TOTAL:        r_cfg.cols_total        <= pwdata[ColsW-1:0];
                REG_HEAD_WIDTH_USED:   r_cfg.head_width_used   <= pwdata[HeadWidthW-1:0];
                REG_HEADS_USED:        r_cfg.heads_used        <= pwdata[HeadsW-1:0];
                REG_LOG2_BLOCK_WIDTH:  r_cfg.log2_block_width  <= pwdata[LogW-1:0];
                REG_LOG2_HEADS:        r_cfg.log2_heads        <= pwdata[LogW-1:0];
                REG_LOG2_ROWS:         r_cfg.log2_rows         <= pwdata[LogW-1:0];
                REG_LOG2_DIAGS_PER_CT: r_cfg.log2_diags_per_ct <= pwdata[LogW-1:0];
                default: ;
            endcase
        end
    end

    // recompute the packed width after any register write: the write sets r_pw_load, which then loads r_packed_width
    assign pw_prod = ProdW'(r_cfg.heads_used) * ProdW'(r_cfg.head_width_used);

    always_comb begin
        if (pw_prod[ProdW-1:PackedW] != '0) begin
            n_packed_width = PackedMax;
        end else begin
            n_packed_width = pw_prod[PackedW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_load      <= 1'b0;
            r_packed_width <= '0;
        end else begin
            r_pw_load <= cfg_wr;
            if (r_pw_load) begin
                r_packed_width <= n_packed_width;
            end
        end
    end

    always_comb begin
        o_cfg              = r_cfg;
        o_cfg.packed_width = r_packed_width;
    end

    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[ApbAddrW-1:2]))
            REG_ROWS_USED:         prdata = ApbDataW'(r_cfg.rows_used);
            REG_COLS_TOTAL:        prdata = ApbDataW'(r_cfg.cols_total);
            REG_HEAD_WIDTH_USED:   prdata = ApbDataW'(r_cfg.head_width_used);
            REG_HEADS_USED:        prdata = ApbDataW'(r_cfg.heads_used);
            REG_LOG2_BLOCK_WIDTH:  prdata = ApbDataW'(r_cfg.log2_block_width);
            REG_LOG2_HEADS:        prdata = ApbDataW'(r_cfg.log2_heads);
            REG_LOG2_ROWS:         prdata = ApbDataW'(r_cfg.log2_rows);
            REG_LOG2_DIAGS_PER_CT: prdata = ApbDataW'(r_cfg.log2_diags_per_ct);
            default:               prdata = '0;
        endcase
    end

    `DSCM_ASSERT_NXT(a_wr_loads_pw, i_clk, i_rst_n, cfg_wr, r_pw_load)
    `DSCM_ASSERT_NXT(a_pw_holds, i_clk, i_rst_n, !cfg_wr && !r_pw_load, $stable(r_packed_width))
    `DSCM_ASSERT_NXT(a_pw_load, i_clk, i_rst_n, r_pw_load, r_packed_width == $past(n_packed_width))

endmodule

// ===== design/dscm_core.sv =====
module dscm_core #(
    parameter int SLOT_COUNT_LOG2 = 15,
    parameter int COL_BITS        = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dscm_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dscm_pkg::CoeffW-1:0]     i_coeff_index,
    input  logic [dscm_pkg::BlockW-1:0]     i_block_index,
    input  logic [dscm_pkg::CtW-1:0]        i_ct_in_block,
    input  logic [dscm_pkg::SlotW-1:0]      i_slot_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_slot_valid,
    output logic [dscm_pkg::CoeffW-1:0]     o_coeff_row,
    output logic [dscm_pkg::ColOutW-1:0]    o_coeff_col,
    output logic [dscm_pkg::SlotW-1:0]      o_slot_out
);
    import dscm_pkg::*;

    `include "diagonal_slot_coeff_mapper_macros.svh"

    localparam int BlkProdW  = BlockW + PackedW;
    localparam int HeadProdW = SlotW + HeadWidthW;
    localparam int SumW      = BlkProdW + 1;
    localparam logic [ColOutW-1:0] ColMask =
        (COL_BITS >= ColOutW) ? '1 : ColOutW'((33'h1 << COL_BITS) - 33'h1);

    logic                  pipe_en;

    // stage 0: input register
    logic                  r_s0_valid;
    logic [CoeffW-1:0]     r_s0_coeff;
    logic [BlockW-1:0]     r_s0_blk;
    logic [CtW-1:0]        r_s0_ct;
    logic [SlotW-1:0]      r_s0_slot;

    // stage 1: split, checks and products
    logic                  r_s1_valid;
    logic [CoeffW-1:0]     r_s1_coeff;
    logic [SlotW-1:0]      r_s1_slot;
    logic                  r_s1_ok;
    logic [SlotW-1:0]      r_s1_local;
    logic [BlkProdW-1:0]   r_s1_blk_prod;
    logic [HeadProdW-1:0]  r_s1_head_prod;

    // stage 2: result register
    logic                  r_out_valid;
    logic                  r_out_slot_valid;
    logic [CoeffW-1:0]     r_out_coeff;
    logic [ColOutW-1:0]    r_out_col;
    logic [SlotW-1:0]      r_out_slot;

    logic [SlotW-1:0]      head;
    logic [SlotW-1:0]      row;
    logic [SlotW-1:0]      diag;
    logic [LogW:0]         hr_shift;
    logic [SlotW-1:0]      ct_sh;
    logic [SlotW-1:0]      diag_sum;
    logic [SlotW-1:0]      wrap_col;
    logic                  slot_ok;
    logic                  diag_ok;
    logic                  head_ok;
    logic                  row_ok;
    logic                  local_ok;
    logic [SumW-1:0]       gcol;
    logic                  col_ok;
    logic                  n_slot_valid;
    logic [ColOutW-1:0]    n_col;

    assign pipe_en    = !r_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    always_comb begin
        hr_shift  = (LogW+1)'(i_cfg.log2_heads) + (LogW+1)'(i_cfg.log2_rows);
        head      = r_s0_slot & ~({SlotW{1'b1}} << i_cfg.log2_heads);
        row       = (r_s0_slot >> i_cfg.log2_heads) & ~({SlotW{1'b1}} << i_cfg.log2_rows);
        diag      = r_s0_slot >> hr_shift;
        ct_sh     = SlotW'(r_s0_ct) << i_cfg.log2_diags_per_ct;
        diag_sum  = ct_sh + diag + row;
        wrap_col  = diag_sum & ~({SlotW{1'b1}} << i_cfg.log2_block_width);
        slot_ok   = ((SlotW+1)'(r_s0_slot) >> SLOT_COUNT_LOG2) == '0;
        diag_ok   = (diag >> i_cfg.log2_diags_per_ct) == '0;
        head_ok   = head < SlotW'(i_cfg.heads_used);
        row_ok    = row < SlotW'(i_cfg.rows_used);
        local_ok  = wrap_col < SlotW'(i_cfg.head_width_used);
    end

    always_comb begin
        gcol = SumW'(r_s1_blk_prod) + SumW'(r_s1_head_prod) + SumW'(r_s1_local);
        col_ok = gcol < SumW'(i_cfg.cols_total);
        n_slot_valid = r_s1_ok && col_ok;
        n_col = n_slot_valid ? (gcol[ColOutW-1:0] & ColMask) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s0_valid  <= i_in_valid;
            r_s1_valid  <= r_s0_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s0_coeff       <= i_coeff_index;
            r_s0_blk         <= i_block_index;
            r_s0_ct          <= i_ct_in_block;
            r_s0_slot        <= i_slot_index;

            r_s1_coeff       <= r_s0_coeff;
            r_s1_slot        <= r_s0_slot;
            r_s1_ok          <= slot_ok && diag_ok && head_ok && row_ok && local_ok;
            r_s1_local       <= wrap_col;
            r_s1_blk_prod    <= BlkProdW'(r_s0_blk) * BlkProdW'(i_cfg.packed_width);
            r_s1_head_prod   <= HeadProdW'(head) * HeadProdW'(i_cfg.head_width_used);

            r_out_slot_valid <= n_slot_valid;
            r_out_coeff      <= r_s1_coeff;
            r_out_col        <= n_col;
            r_out_slot       <= r_s1_slot;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_valid = r_out_slot_valid;
    assign o_coeff_row  = r_out_coeff;
    assign o_coeff_col  = r_out_col;
    assign o_slot_out   = r_out_slot;

    `DSCM_ASSERT_IMP(a_invalid_col_zero, i_clk, i_rst_n, r_out_valid && !r_out_slot_valid, r_out_col == '0)
    `DSCM_ASSERT_IMP(a_col_in_mask, i_clk, i_rst_n, r_out_valid, (r_out_col & ~ColMask) == '0)
    `DSCM_ASSERT_NXT(a_item_reaches_out, i_clk, i_rst_n, r_s0_valid && pipe_en ##1 pipe_en, r_out_valid)

endmodule

// ===== design/diagonal_slot_coeff_mapper.sv =====
// Maps one slot of a diagonally packed vector to the coefficient row and global column
// to read, plus a valid flag (column reads zero when invalid). One item is accepted
// per clock unless the output stalls, and its result lands in a result register; the
// three-stage pipeline (input register, field split with the block and head
// multipliers, column sum and range checks) moves only when the result register is
// empty or being taken, so a stalled output stalls input acceptance in the same cycle.
// Registers sit on an APB port at byte address 4*index; the packed width
// (heads_used * head_width_used, saturated to 20 bits) is reloaded via r_pw_load after
// any register write, so items may follow a write from the next cycle on.
module diagonal_slot_coeff_mapper #(
    parameter int SLOT_COUNT_LOG2 = 15,
    parameter int COL_BITS        = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dscm_pkg::ApbAddrW-1:0]   paddr,
    input  logic [dscm_pkg::ApbDataW-1:0]   pwdata,
    output logic [dscm_pkg::ApbDataW-1:0]   prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dscm_pkg::CoeffW-1:0]     i_coeff_index,
    input  logic [dscm_pkg::BlockW-1:0]     i_block_index,
    input  logic [dscm_pkg::CtW-1:0]        i_ct_in_block,
    input  logic [dscm_pkg::SlotW-1:0]      i_slot_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_slot_valid,
    output logic [dscm_pkg::CoeffW-1:0]     o_coeff_row,
    output logic [dscm_pkg::ColOutW-1:0]    o_coeff_col,
    output logic [dscm_pkg::SlotW-1:0]      o_slot_out
);
    import dscm_pkg::*;

    t_cfg cfg;

    dscm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dscm_core #(
        .SLOT_COUNT_LOG2 (SLOT_COUNT_LOG2),
        .COL_BITS        (COL_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_coeff_index (i_coeff_index),
        .i_block_index (i_block_index),
        .i_ct_in_block (i_ct_in_block),
        .i_slot_index  (i_slot_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot_valid  (o_slot_valid),
        .o_coeff_row   (o_coeff_row),
        .o_coeff_col   (o_coeff_col),
        .o_slot_out    (o_slot_out)
    );

endmodule
